/* hdl/tdp_pkg.sv */
package tdp_pkg;

    localparam int COUNT_BITS_DEFAULT  = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int BYTE_W   = 8;
    localparam int STATUS_W = 2;
    localparam int MAC_W    = 48;
    localparam int LEN_W    = 16;
    localparam int HDR_IDX_W = 2;

    localparam logic [BYTE_W-1:0] TAG_PAD = 8'h00;
    localparam logic [BYTE_W-1:0] TAG_END = 8'h01;
    localparam logic [BYTE_W-1:0] TAG_FCS = 8'h11;
    localparam logic [BYTE_W-1:0] TAG_MAC = 8'h3C;

    localparam logic [BYTE_W-1:0] FCS_TAG_LEN = 8'd1;
    localparam logic [BYTE_W-1:0] MAC_TAG_LEN = 8'd6;

    localparam logic [HDR_IDX_W-1:0] HDR_LAST_IDX = 2'd3;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_TYPE    = 3'd1,
        PH_LEN     = 3'd2,
        PH_DATA    = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_DROP    = 3'd5
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_HDR   = 2'd1,
        ST_TRUNC = 2'd2,
        ST_FCS   = 2'd3
    } status_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              payload;
        logic              last;
        status_t           status;
        logic [MAC_W-1:0]  mac;
        logic              mac_found;
        logic [LEN_W-1:0]  len;
    } result_t;

    function automatic logic [BYTE_W-1:0] hdr_expect(input logic [HDR_IDX_W-1:0] idx);
        logic [BYTE_W-1:0] val;
        unique case (idx)
            2'd0:    val = 8'h01;
            2'd1:    val = 8'h00;
            2'd2:    val = 8'h00;
            default: val = 8'h12;
        endcase
        return val;
    endfunction

endpackage

/* hdl/tdp_front.sv */
module tdp_front
    import tdp_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_wr_en,
    input  logic              cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              in_last,
    input  logic              q_space,
    output logic              q_push,
    output result_t           q_data
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic                  fcs_err_allow_reg;
    phase_t                phase_reg, phase_next;
    logic [HDR_IDX_W-1:0]  hdr_idx_reg, hdr_idx_next;
    logic [BYTE_W-1:0]     tag_kind_reg, tag_kind_next;
    logic [BYTE_W-1:0]     tag_len_reg, tag_len_next;
    logic [BYTE_W-1:0]     tag_rem_reg, tag_rem_next;
    logic [MAC_W-1:0]      mac_reg, mac_next;
    logic                  mac_seen_reg, mac_seen_next;
    status_t               err_reg, err_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  emit;
    logic                  accept;
    logic [LEN_W-1:0]      len_out;

    assign in_ready = q_space;
    assign accept   = in_valid && in_ready;

    generate
        if (COUNT_BITS >= LEN_W)
        begin : g_len_wide
            assign len_out = count_next[LEN_W-1:0];
        end
        else
        begin : g_len_narrow
            assign len_out = {{(LEN_W-COUNT_BITS){1'b0}}, count_next};
        end
    endgenerate

    always_comb
    begin
        phase_next    = phase_reg;
        hdr_idx_next  = hdr_idx_reg;
        tag_kind_next = tag_kind_reg;
        tag_len_next  = tag_len_reg;
        tag_rem_next  = tag_rem_reg;
        mac_next      = mac_reg;
        mac_seen_next = mac_seen_reg;
        err_next      = err_reg;
        count_next    = count_reg;
        emit          = 1'b0;

        unique case (phase_reg)
            PH_HEADER:
            begin
                if (in_last)
                begin
                    err_next   = ST_TRUNC;
                    phase_next = PH_DROP;
                end
                else if (in_byte != hdr_expect(hdr_idx_reg))
                begin
                    err_next   = ST_HDR;
                    phase_next = PH_DROP;
                end
                else if (hdr_idx_reg == HDR_LAST_IDX)
                begin
                    hdr_idx_next = '0;
                    phase_next   = PH_TYPE;
                end
                else
                begin
                    hdr_idx_next = hdr_idx_reg + 1'b1;
                end
            end
            PH_TYPE:
            begin
                if (in_last)
                begin
                    err_next   = ST_TRUNC;
                    phase_next = PH_DROP;
                end
                else if (in_byte == TAG_END)
                begin
                    phase_next = PH_PAYLOAD;
                end
                else if (in_byte != TAG_PAD)
                begin
                    tag_kind_next = in_byte;
                    phase_next    = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (in_last)
                begin
                    err_next   = ST_TRUNC;
                    phase_next = PH_DROP;
                end
                else
                begin
                    tag_len_next = in_byte;
                    tag_rem_next = in_byte;
                    phase_next   = (in_byte == '0) ? PH_TYPE : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (in_last)
                begin
                    err_next   = ST_TRUNC;
                    phase_next = PH_DROP;
                end
                else if (tag_kind_reg == TAG_FCS && tag_len_reg == FCS_TAG_LEN &&
                         !fcs_err_allow_reg && in_byte != '0)
                begin
                    err_next   = ST_FCS;
                    phase_next = PH_DROP;
                end
                else
                begin
                    if (tag_kind_reg == TAG_MAC && tag_len_reg == MAC_TAG_LEN)
                    begin
                        mac_next = {mac_reg[MAC_W-BYTE_W-1:0], in_byte};
                    end
                    tag_rem_next = tag_rem_reg - 1'b1;
                    if (tag_rem_next == '0)
                    begin
                        if (tag_kind_reg == TAG_MAC && tag_len_reg == MAC_TAG_LEN)
                        begin
                            mac_seen_next = 1'b1;
                        end
                        phase_next = PH_TYPE;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit = 1'b1;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            default:
            begin
            end
        endcase

        q_push            = accept && (emit || in_last);
        q_data.data       = emit ? in_byte : '0;
        q_data.payload    = emit;
        q_data.last       = in_last;
        q_data.status     = err_next;
        q_data.mac        = mac_seen_next ? mac_next : '0;
        q_data.mac_found  = mac_seen_next;
        q_data.len        = len_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcs_err_allow_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            fcs_err_allow_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            hdr_idx_reg  <= '0;
            tag_kind_reg <= '0;
            tag_len_reg  <= '0;
            tag_rem_reg  <= '0;
            mac_reg      <= '0;
            mac_seen_reg <= 1'b0;
            err_reg      <= ST_OK;
            count_reg    <= '0;
        end
        else if (accept)
        begin
            if (in_last)
            begin
                phase_reg    <= PH_HEADER;
                hdr_idx_reg  <= '0;
                tag_kind_reg <= '0;
                tag_len_reg  <= '0;
                tag_rem_reg  <= '0;
                mac_reg      <= '0;
                mac_seen_reg <= 1'b0;
                err_reg      <= ST_OK;
                count_reg    <= '0;
            end
            else
            begin
                phase_reg    <= phase_next;
                hdr_idx_reg  <= hdr_idx_next;
                tag_kind_reg <= tag_kind_next;
                tag_len_reg  <= tag_len_next;
                tag_rem_reg  <= tag_rem_next;
                mac_reg      <= mac_next;
                mac_seen_reg <= mac_seen_next;
                err_reg      <= err_next;
                count_reg    <= count_next;
            end
        end
    end

endmodule

/* hdl/tdp_queue.sv */
module tdp_queue
    import tdp_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    space,
    output logic    pop_valid,
    input  logic    pop_ready,
    output result_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    result_t          mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             pop;

    assign space     = (cnt_reg != CNT_FULL);
    assign pop_valid = (cnt_reg != '0);
    assign pop       = pop_valid && pop_ready;
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

/* hdl/tzsp_decap_tag_parser_top.sv */
// Strips TZSP encapsulation from a byte stream: one byte is taken per transfer, and with
// the output side ready the block sustains one byte per clock cycle. Results leave
// through a small result queue of QUEUE_DEPTH entries, which registers them and lets
// the parser keep taking bytes while results wait.
// Each payload byte and each packet's last byte give one result; the status, MAC and
// length fields are final on the result with end set.
module tzsp_decap_tag_parser_top
    import tdp_pkg::*;
#(
    parameter int COUNT_BITS  = COUNT_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  logic                cfg_wr_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [BYTE_W-1:0]   in_byte,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [BYTE_W-1:0]   out_byte,
    output logic                out_payload,
    output logic                out_end,
    output logic [STATUS_W-1:0] pkt_status,
    output logic [MAC_W-1:0]    station_mac,
    output logic                mac_found,
    output logic [LEN_W-1:0]    payload_len
);

    logic    q_space;
    logic    q_push;
    result_t q_in;
    result_t q_out;

    tdp_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .q_space     (q_space),
        .q_push      (q_push),
        .q_data      (q_in)
    );

    tdp_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .space     (q_space),
        .pop_valid (out_valid),
        .pop_ready (out_ready),
        .pop_data  (q_out)
    );

    assign out_byte    = q_out.data;
    assign out_payload = q_out.payload;
    assign out_end     = q_out.last;
    assign pkt_status  = q_out.status;
    assign station_mac = q_out.mac;
    assign mac_found   = q_out.mac_found;
    assign payload_len = q_out.len;

endmodule

/* dv/tb_tzsp_decap_tag_parser_top.sv */
`timescale 1ns / 1ps

module tb_tzsp_decap_tag_parser_top;
    import tdp_pkg::*;

    localparam int STALL_LIMIT = 2000;

    typedef struct {
        logic [BYTE_W-1:0] value;
        logic              last;
    } pkt_byte_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic                cfg_wr_data = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [BYTE_W-1:0]   in_byte = '0;
    logic                in_last = 1'b0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [BYTE_W-1:0]   out_byte;
    logic                out_payload;
    logic                out_end;
    logic [STATUS_W-1:0] pkt_status;
    logic [MAC_W-1:0]    station_mac;
    logic                mac_found;
    logic [LEN_W-1:0]    payload_len;

    pkt_byte_t         tx_bytes[$];
    result_t           expected_results[$];
    logic [BYTE_W-1:0] pkt_buf[$];

    // Parser state tracked by the testbench.
    logic [BYTE_W-1:0] hdr_bytes [4] = '{8'h01, 8'h00, 8'h00, 8'h12};
    logic              fcs_allow = 1'b0;
    phase_t            prs_phase = PH_HEADER;
    logic [1:0]        hdr_pos = '0;
    logic [BYTE_W-1:0] cur_tag = '0;
    logic [BYTE_W-1:0] cur_len = '0;
    logic [BYTE_W-1:0] bytes_left = '0;
    logic [MAC_W-1:0]  mac_acc = '0;
    logic              mac_ok = 1'b0;
    status_t           pkt_err = ST_OK;
    logic [LEN_W-1:0]  pay_cnt = '0;

    int      in_gap = 0;
    int      out_gap = 0;
    bit      send_hold = 1'b0;
    int      errors = 0;
    int      stall_cycles = 0;
    int      queued_items = 0;
    result_t exp_r;

    tzsp_decap_tag_parser_top u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_byte    (out_byte),
        .out_payload (out_payload),
        .out_end     (out_end),
        .pkt_status  (pkt_status),
        .station_mac (station_mac),
        .mac_found   (mac_found),
        .payload_len (payload_len)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    task automatic drop_packet(input status_t code);
        pkt_err   = code;
        prs_phase = PH_DROP;
    endtask

    task automatic parse_byte(input logic [BYTE_W-1:0] b, input logic last);
        bit      emit;
        result_t r;
        emit = 1'b0;
        case (prs_phase)
            PH_HEADER:
            begin
                if (last)
                    drop_packet(ST_TRUNC);
                else if (b != hdr_bytes[hdr_pos])
                    drop_packet(ST_HDR);
                else if (hdr_pos == 2'd3)
                begin
                    hdr_pos   = '0;
                    prs_phase = PH_TYPE;
                end
                else
                    hdr_pos = hdr_pos + 2'd1;
            end
            PH_TYPE:
            begin
                if (last)
                    drop_packet(ST_TRUNC);
                else if (b == TAG_END)
                    prs_phase = PH_PAYLOAD;
                else if (b != TAG_PAD)
                begin
                    cur_tag   = b;
                    prs_phase = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (last)
                    drop_packet(ST_TRUNC);
                else
                begin
                    cur_len    = b;
                    bytes_left = b;
                    prs_phase  = (b == 8'd0) ? PH_TYPE : PH_DATA;
                end
            end
            PH_DATA:
            begin
                if (last)
                    drop_packet(ST_TRUNC);
                else if (cur_tag == TAG_FCS && cur_len == FCS_TAG_LEN && !fcs_allow
                         && b != 8'd0)
                    drop_packet(ST_FCS);
                else
                begin
                    if (cur_tag == TAG_MAC && cur_len == MAC_TAG_LEN)
                        mac_acc = {mac_acc[MAC_W-9:0], b};
                    bytes_left = bytes_left - 8'd1;
                    if (bytes_left == 8'd0)
                    begin
                        if (cur_tag == TAG_MAC && cur_len == MAC_TAG_LEN)
                            mac_ok = 1'b1;
                        prs_phase = PH_TYPE;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                emit = 1'b1;
                if (pay_cnt != '1)
                    pay_cnt = pay_cnt + 1'b1;
            end
            default:
            begin
            end
        endcase
        if (emit || last)
        begin
            r.data      = emit ? b : '0;
            r.payload   = emit;
            r.last      = last;
            r.status    = pkt_err;
            r.mac       = mac_ok ? mac_acc : '0;
            r.mac_found = mac_ok;
            r.len       = pay_cnt;
            expected_results.push_back(r);
        end
        if (last)
        begin
            prs_phase  = PH_HEADER;
            hdr_pos    = '0;
            cur_tag    = '0;
            cur_len    = '0;
            bytes_left = '0;
            mac_acc    = '0;
            mac_ok     = 1'b0;
            pkt_err    = ST_OK;
            pay_cnt    = '0;
        end
    endtask

    // Sender: one transfer per pending byte, with a random gap before each.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                parse_byte(in_byte, in_last);
                in_gap = int'($urandom_range(0, 9));
            end
            if (!in_valid || in_ready)
            begin
                if (in_gap != 0)
                begin
                    in_gap = in_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (tx_bytes.size() != 0 && !send_hold)
                begin
                    in_valid <= 1'b1;
                    in_byte  <= tx_bytes[0].value;
                    in_last  <= tx_bytes[0].last;
                    void'(tx_bytes.pop_front());
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Receiver: checks every result transfer against the oldest expectation.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected result: byte=%h pay=%b end=%b st=%0d len=%0d",
                                 out_byte, out_payload, out_end, pkt_status,
                                 payload_len);
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (out_byte !== exp_r.data || out_payload !== exp_r.payload ||
                        out_end !== exp_r.last || pkt_status !== exp_r.status ||
                        station_mac !== exp_r.mac || mac_found !== exp_r.mac_found ||
                        payload_len !== exp_r.len)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                        begin
                            $display({"mismatch: expected byte=%h pay=%b end=%b st=%0d",
                                      " mac=%h found=%b len=%0d"},
                                     exp_r.data, exp_r.payload, exp_r.last, exp_r.status,
                                     exp_r.mac, exp_r.mac_found, exp_r.len);
                            $display({"          actual   byte=%h pay=%b end=%b st=%0d",
                                      " mac=%h found=%b len=%0d"},
                                     out_byte, out_payload, out_end, pkt_status,
                                     station_mac, mac_found, payload_len);
                        end
                    end
                end
                out_gap = int'($urandom_range(0, 9));
            end
            else if (out_gap != 0)
                out_gap = out_gap - 1;
            out_ready <= (out_gap == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("tb_tzsp_decap_tag_parser_top: done, errors");
            $finish;
        end
    end

    task automatic wait_drained();
        while (tx_bytes.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_fcs_allow(input logic v);
        wait_drained();
        repeat (8) @(posedge clk);
        cfg_wr_data <= v;
        cfg_wr_en   <= 1'b1;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        fcs_allow = v;
        @(posedge clk);
    endtask

    task automatic add_header();
        pkt_buf.push_back(8'h01);
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(8'h12);
    endtask

    task automatic add_random(input int n);
        int i;
        for (i = 0; i < n; i++)
            pkt_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // Sends the first cut bytes of the packet buffer, the last of them flagged.
    task automatic flush_packet(input int cut, input bit pause_midway);
        int        i;
        pkt_byte_t pb;
        for (i = 0; i < cut; i++)
        begin
            if (pause_midway && i == cut / 2)
                wait_drained();
            pb.value = pkt_buf[i];
            pb.last  = (i == cut - 1);
            tx_bytes.push_back(pb);
        end
        queued_items = queued_items + cut;
        pkt_buf.delete();
    endtask

    task automatic queue_random_packet(input bit pause_midway);
        int n_tags;
        int k;
        int len;
        int cut;
        pkt_buf.delete();
        if ($urandom_range(0, 9) == 0)
            add_random(int'($urandom_range(1, 8)));
        else
        begin
            add_header();
            if ($urandom_range(0, 19) == 0)
                pkt_buf[$urandom_range(0, 3)] = 8'($urandom_range(0, 255));
            n_tags = int'($urandom_range(0, 4));
            for (k = 0; k < n_tags; k++)
            begin
                case ($urandom_range(0, 5))
                    0:
                        pkt_buf.push_back(TAG_PAD);
                    1:
                    begin
                        pkt_buf.push_back(TAG_FCS);
                        pkt_buf.push_back(FCS_TAG_LEN);
                        pkt_buf.push_back($urandom_range(0, 1) ? 8'h00
                                          : 8'($urandom_range(1, 255)));
                    end
                    2:
                    begin
                        pkt_buf.push_back(TAG_MAC);
                        pkt_buf.push_back(MAC_TAG_LEN);
                        add_random(6);
                    end
                    3:
                    begin
                        len = int'($urandom_range(0, 8));
                        pkt_buf.push_back(TAG_MAC);
                        pkt_buf.push_back(8'(len));
                        add_random(len);
                    end
                    4:
                    begin
                        len = int'($urandom_range(0, 3));
                        pkt_buf.push_back(TAG_FCS);
                        pkt_buf.push_back(8'(len));
                        add_random(len);
                    end
                    default:
                    begin
                        len = int'($urandom_range(0, 5));
                        pkt_buf.push_back(8'($urandom_range(2, 255)));
                        pkt_buf.push_back(8'(len));
                        add_random(len);
                    end
                endcase
            end
            pkt_buf.push_back(TAG_END);
            add_random(int'($urandom_range(1, 8)));
        end
        cut = pkt_buf.size();
        if ($urandom_range(0, 5) == 0)
            cut = int'($urandom_range(1, pkt_buf.size()));
        flush_packet(cut, pause_midway);
    endtask

    task automatic queue_random_items(input int target, input bit pause_once);
        int start;
        bit paused;
        start  = queued_items;
        paused = 1'b0;
        while (queued_items - start < target)
        begin
            queue_random_packet(pause_once && !paused);
            paused = 1'b1;
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_fcs_allow(1'b0);

        // Packet that ends inside the header.
        pkt_buf = {8'h01, 8'h00, 8'h00};
        flush_packet(pkt_buf.size(), 1'b0);
        // Header mismatch, then a dropped last byte.
        pkt_buf = {8'h01, 8'hFF, 8'h00};
        flush_packet(pkt_buf.size(), 1'b0);
        // Padding, a sensor MAC tag, a zero-length tag, the end tag and payload.
        add_header();
        pkt_buf.push_back(TAG_PAD);
        pkt_buf.push_back(TAG_MAC);
        pkt_buf.push_back(MAC_TAG_LEN);
        pkt_buf.push_back(8'hFF);
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(8'h12);
        pkt_buf.push_back(8'h34);
        pkt_buf.push_back(8'h56);
        pkt_buf.push_back(8'hAB);
        pkt_buf.push_back(8'h05);
        pkt_buf.push_back(8'h00);
        pkt_buf.push_back(TAG_END);
        pkt_buf.push_back(8'hFF);
        pkt_buf.push_back(8'h00);
        flush_packet(pkt_buf.size(), 1'b0);
        // Nonzero FCS value while errors are not allowed.
        add_header();
        pkt_buf.push_back(TAG_FCS);
        pkt_buf.push_back(FCS_TAG_LEN);
        pkt_buf.push_back(8'hFF);
        pkt_buf.push_back(8'h00);
        flush_packet(pkt_buf.size(), 1'b0);

        queue_random_items(90, 1'b1);

        set_fcs_allow(1'b1);
        add_header();
        pkt_buf.push_back(TAG_FCS);
        pkt_buf.push_back(FCS_TAG_LEN);
        pkt_buf.push_back(8'hFF);
        pkt_buf.push_back(TAG_END);
        pkt_buf.push_back(8'h55);
        flush_packet(pkt_buf.size(), 1'b0);
        queue_random_items(90, 1'b0);

        set_fcs_allow(1'b0);
        queue_random_items(90, 1'b0);

        set_fcs_allow(1'b1);
        queue_random_items(90, 1'b0);

        wait_drained();
        repeat (20) @(posedge clk);
        if (errors == 0)
            $display("tb_tzsp_decap_tag_parser_top: done, clean");
        else
            $display("tb_tzsp_decap_tag_parser_top: done, errors");
        $finish;
    end

endmodule
